### hw/rtl/range_bounded_prime_test_assert.svh
// Assertion helpers for the range-bounded prime test block.
`ifndef RANGE_BOUNDED_PRIME_TEST_ASSERT_SVH
`define RANGE_BOUNDED_PRIME_TEST_ASSERT_SVH

`ifndef SYNTHESIS
`define RBPT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rbpt: same-cycle check failed");
`define RBPT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rbpt: next-cycle check failed");
`else
`define RBPT_ASSERT_SAME(lbl, ante, cons)
`define RBPT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/rbpt_pkg.sv
package rbpt_pkg;

  localparam int unsigned VALUE_BITS     = 27;
  // Widest odd divisor ever loaded is just above sqrt(2^VALUE_BITS)
  localparam int unsigned DIV_BITS       = (VALUE_BITS + 1) / 2 + 1;
  localparam int unsigned SQ_BITS        = VALUE_BITS + 2;
  localparam int unsigned CNT_BITS       = $clog2(VALUE_BITS + 1);
  localparam int unsigned IN_TDATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_BITS = 8;

  localparam logic REG_LOW  = 1'b0;
  localparam logic REG_HIGH = 1'b1;

  typedef struct packed {
    logic                  start;
    logic [VALUE_BITS-1:0] dividend;
    logic [DIV_BITS-1:0]   divisor;
  } rem_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

  typedef struct packed {
    logic is_prime;
    logic in_range;
  } result_t;

endpackage

### hw/rtl/rbpt_rem.sv
module rbpt_rem (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rbpt_pkg::rem_req_t    req_i,
  output rbpt_pkg::rem_status_t status_o
);
  import rbpt_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] shift_q, shift_d;
  logic [DIV_BITS-1:0]   rem_q, rem_d;
  logic [DIV_BITS-1:0]   dvs_q, dvs_d;
  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS+1:0]   diff;

  // One quotient bit per cycle: bring down the next dividend bit, subtract if it fits
  assign trial = {rem_q, shift_q[VALUE_BITS-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      cnt_d   = CNT_BITS'(VALUE_BITS);
      shift_d = req_i.dividend;
      rem_d   = '0;
      dvs_d   = req_i.divisor;
    end else if (busy_q) begin
      shift_d = {shift_q[VALUE_BITS-2:0], 1'b0};
      rem_d   = diff[DIV_BITS+1] ? trial[DIV_BITS-1:0] : diff[DIV_BITS-1:0];
      cnt_d   = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
  end

  assign status_o.done = done_q;
  assign status_o.zero = (rem_q == '0);

endmodule

### hw/rtl/range_bounded_prime_test.sv
// Range-bounded prime test: each request on the s_axis side carries one candidate and yields
// exactly one result on the m_axis side. A candidate outside [low_bound, high_bound], or one
// that is 0, 1 or even, is resolved without any trial division; 2 is reported prime. An odd
// in-range candidate is tried against 3, 5, 7, ... while the divisor squared stays at or
// below it, each trial running in the single bit-serial remainder unit. One candidate is
// worked on at a time; the next is taken as soon as the previous result has moved into the
// output register. Bounds are written through cfg_we_i / cfg_idx_i / cfg_data_i (index 0
// low bound, index 1 high bound); the user must write them only while no request is in
// flight, as the block itself does not enforce this.
`include "range_bounded_prime_test_assert.svh"

module range_bounded_prime_test (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [26:0] candidate, upper bits zero
  input  logic [rbpt_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] in_range, [1] is_prime, upper bits zero
  output logic [rbpt_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [rbpt_pkg::VALUE_BITS-1:0]      cfg_data_i
);
  import rbpt_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [VALUE_BITS-1:0] low_q, high_q;
  logic [VALUE_BITS-1:0] n_q, n_d;
  logic [DIV_BITS-1:0]   d_q, d_d;
  logic [SQ_BITS-1:0]    sq_q, sq_d;
  result_t               res_q, res_d;
  result_t               out_q;
  logic                  out_valid_q, out_valid_d;
  logic                  out_load;
  logic                  accept;
  logic [VALUE_BITS-1:0] cand;
  logic                  cand_in_range;
  rem_req_t              rem_req;
  rem_status_t           rem_st;

  assign cand          = s_axis_tdata[VALUE_BITS-1:0];
  assign cand_in_range = (cand >= low_q) && (cand <= high_q);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  rbpt_rem u_rem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (rem_req),
    .status_o (rem_st)
  );

  always_comb begin
    state_d          = state_q;
    n_d              = n_q;
    d_d              = d_q;
    sq_d             = sq_q;
    res_d            = res_q;
    out_load         = 1'b0;
    rem_req.start    = 1'b0;
    rem_req.dividend = n_q;
    rem_req.divisor  = d_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          n_d            = cand;
          d_d            = DIV_BITS'(3);
          sq_d           = SQ_BITS'(9);
          res_d.in_range = cand_in_range;
          res_d.is_prime = 1'b0;
          state_d        = ST_DONE;
          if (cand_in_range) begin
            if (cand == VALUE_BITS'(2)) begin
              res_d.is_prime = 1'b1;
            end else if (cand[0] && (cand != VALUE_BITS'(1))) begin
              state_d = ST_CHECK;
            end
          end
        end
      end
      ST_CHECK: begin
        // Divisor squared past the candidate: no factor left to find
        if (sq_q > SQ_BITS'(n_q)) begin
          res_d.is_prime = 1'b1;
          state_d        = ST_DONE;
        end else begin
          rem_req.start = 1'b1;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_st.done) begin
          if (rem_st.zero) begin
            state_d = ST_DONE;
          end else begin
            // (d + 2)^2 = d^2 + 4d + 4
            d_d     = d_q + DIV_BITS'(2);
            sq_d    = sq_q + SQ_BITS'({d_q, 2'b00}) + SQ_BITS'(4);
            state_d = ST_CHECK;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      low_q       <= '0;
      high_q      <= '1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_LOW) begin
          low_q <= cfg_data_i;
        end
        if (cfg_idx_i == REG_HIGH) begin
          high_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    d_q   <= d_d;
    sq_q  <= sq_d;
    res_q <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_BITS - 2){1'b0}}, out_q};

  `RBPT_ASSERT_SAME(a_prime_needs_range, out_valid_q && !out_q.in_range, !out_q.is_prime)
  `RBPT_ASSERT_SAME(a_rem_done_in_div, rem_st.done, state_q == ST_DIV)
  `RBPT_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != ST_IDLE)
  `RBPT_ASSERT_SAME(a_divisor_odd, state_q == ST_CHECK || state_q == ST_DIV, d_q[0])

endmodule

### test/range_bounded_prime_test_tb.sv
module range_bounded_prime_test_tb;
  import rbpt_pkg::*;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
  // largest prime below 2^27, the longest trial search the block can face
  localparam logic [VALUE_BITS-1:0] TOP_PRIME = 27'd134217689;
  localparam int unsigned STALL_LIMIT = 1_000_000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RAND_PHASES = 5;
  localparam int unsigned PHASE_ITEMS = 20;

  typedef enum logic {ROW_ITEM, ROW_BOUNDS} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [VALUE_BITS-1:0] a;
    logic [VALUE_BITS-1:0] b;
    logic                  typed;
    result_t               verdict;
  } stim_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic                      cfg_we_i = 1'b0;
  logic                      cfg_idx_i = REG_LOW;
  logic [VALUE_BITS-1:0]     cfg_data_i = '0;

  logic [VALUE_BITS-1:0] bound_lo = '0;
  logic [VALUE_BITS-1:0] bound_hi = VALUE_MAX;
  result_t               verdict_q[$];
  int                    errors = 0;
  int                    n_sent = 0;
  int                    n_checked = 0;
  int                    n_prime = 0;
  int                    n_outside = 0;
  int unsigned           idle_cycles = 0;
  bit                    quiet = 1'b0;
  bit                    hold_req = 1'b0;

  always #10 clk_i = ~clk_i;

  range_bounded_prime_test dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  function automatic bit trial_prime(logic [VALUE_BITS-1:0] c);
    longint unsigned n;
    longint unsigned d;
    n = 64'(c);
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (n % 2 == 0) return 1'b0;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic result_t predict_verdict(logic [VALUE_BITS-1:0] c);
    result_t v;
    v.in_range = (c >= bound_lo) && (c <= bound_hi);
    v.is_prime = v.in_range && trial_prime(c);
    return v;
  endfunction

  function automatic stim_row_t item_row(logic [VALUE_BITS-1:0] c, logic typed,
                                         logic in_range, logic is_prime);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.a = c;
    r.b = '0;
    r.typed = typed;
    r.verdict.in_range = in_range;
    r.verdict.is_prime = is_prime;
    return r;
  endfunction

  function automatic stim_row_t bounds_row(logic [VALUE_BITS-1:0] lo,
                                           logic [VALUE_BITS-1:0] hi);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BOUNDS;
    r.a = lo;
    r.b = hi;
    return r;
  endfunction

  // Mostly cheap candidates: small values, or wide ones with a small factor.
  function automatic logic [VALUE_BITS-1:0] next_candidate();
    logic [VALUE_BITS-1:0] r;
    int unsigned           q;
    r = VALUE_BITS'($urandom);
    case ($urandom_range(0, 11))
      0, 1, 2, 3, 4: return VALUE_BITS'($urandom_range(0, 4095));
      5, 6: return VALUE_BITS'($urandom_range(0, 1 << 20));
      7: return {r[VALUE_BITS-1:1], 1'b0};
      8: return VALUE_BITS'(r - (r % 3));
      9: begin
        q = 2 * $urandom_range(2, 50) + 1;
        return VALUE_BITS'((r / q) * q);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return bound_lo - 1'b1;
          1: return bound_lo;
          2: return bound_hi;
          default: return bound_hi + 1'b1;
        endcase
      end
    endcase
  endfunction

  // Leaves tvalid high on return; the caller offers again or drains in the same step.
  task automatic offer_candidate(input logic [VALUE_BITS-1:0] c, input logic typed,
                                 input result_t typed_v);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TDATA_BITS'(c);
    do @(posedge clk_i); while (!s_axis_tready);
    verdict_q.insert(verdict_q.size(), typed ? typed_v : predict_verdict(c));
    n_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_bounds(input logic [VALUE_BITS-1:0] lo, input logic [VALUE_BITS-1:0] hi);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_LOW;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i <= REG_HIGH;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bound_lo = lo;
    bound_hi = hi;
  endtask

  // Result side: random stalls, one long hold-off on request.
  initial begin
    int      stall;
    result_t got;
    result_t want;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 10);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = result_t'(m_axis_tdata[1:0]);
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: result %b arrived with nothing expected", $time, m_axis_tdata);
      end else begin
        want = verdict_q.pop_front();
        n_checked++;
        n_prime += int'(got.is_prime);
        n_outside += int'(!got.in_range);
        if (got.in_range !== want.in_range) begin
          errors++;
          $display("%0t: in_range expected %0b, got %0b", $time, want.in_range, got.in_range);
        end
        if (got.is_prime !== want.is_prime) begin
          errors++;
          $display("%0t: is_prime expected %0b, got %0b", $time, want.is_prime, got.is_prime);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    stim_row_t             rows[$];
    logic [VALUE_BITS-1:0] lo;
    logic [VALUE_BITS-1:0] hi;
    int                    n_directed;

    // reset bounds: whole range
    rows.insert(rows.size(), item_row(27'd0, 1'b1, 1'b1, 1'b0));
    rows.insert(rows.size(), item_row(27'd1, 1'b1, 1'b1, 1'b0));
    rows.insert(rows.size(), item_row(27'd2, 1'b1, 1'b1, 1'b1));
    rows.insert(rows.size(), item_row(27'd3, 1'b0, 1'b0, 1'b0));
    rows.insert(rows.size(), item_row(27'd4, 1'b1, 1'b1, 1'b0));
    rows.insert(rows.size(), item_row(27'd9, 1'b0, 1'b0, 1'b0));
    rows.insert(rows.size(), item_row(27'd65521, 1'b0, 1'b0, 1'b0));
    rows.insert(rows.size(), item_row(VALUE_MAX, 1'b0, 1'b0, 1'b0));
    rows.insert(rows.size(), item_row(VALUE_MAX - 1'b1, 1'b1, 1'b1, 1'b0));
    rows.insert(rows.size(), item_row(TOP_PRIME, 1'b0, 1'b0, 1'b0));
    // narrow window, both edges
    rows.insert(rows.size(), bounds_row(27'd100, 27'd200));
    rows.insert(rows.size(), item_row(27'd99, 1'b1, 1'b0, 1'b0));
    rows.insert(rows.size(), item_row(27'd100, 1'b1, 1'b1, 1'b0));
    rows.insert(rows.size(), item_row(27'd101, 1'b0, 1'b0, 1'b0));
    rows.insert(rows.size(), item_row(27'd199, 1'b0, 1'b0, 1'b0));
    rows.insert(rows.size(), item_row(27'd200, 1'b1, 1'b1, 1'b0));
    rows.insert(rows.size(), item_row(27'd201, 1'b1, 1'b0, 1'b0));
    // inverted bounds reject everything
    rows.insert(rows.size(), bounds_row(27'd500, 27'd400));
    rows.insert(rows.size(), item_row(27'd401, 1'b1, 1'b0, 1'b0));
    rows.insert(rows.size(), item_row(27'd450, 1'b1, 1'b0, 1'b0));
    rows.insert(rows.size(), item_row(27'd500, 1'b1, 1'b0, 1'b0));
    rows.insert(rows.size(), bounds_row(VALUE_MAX, VALUE_MAX));
    rows.insert(rows.size(), item_row(VALUE_MAX, 1'b0, 1'b0, 1'b0));
    rows.insert(rows.size(), item_row(27'd0, 1'b1, 1'b0, 1'b0));
    rows.insert(rows.size(), bounds_row(27'd0, 27'd0));
    rows.insert(rows.size(), item_row(27'd0, 1'b1, 1'b1, 1'b0));
    rows.insert(rows.size(), item_row(27'd2, 1'b1, 1'b0, 1'b0));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_BOUNDS)
        set_bounds(rows[i].a, rows[i].b);
      else
        offer_candidate(rows[i].a, rows[i].typed, rows[i].verdict);
    end
    n_directed = n_sent;

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin
          lo = '0;
          hi = VALUE_MAX;
        end
        1: begin
          lo = '0;
          hi = 27'd65535;
        end
        2: begin
          lo = VALUE_BITS'($urandom_range(0, 2000));
          hi = lo + VALUE_BITS'($urandom_range(0, 3000));
        end
        3: begin
          lo = VALUE_BITS'($urandom_range(VALUE_MAX / 2, VALUE_MAX));
          hi = VALUE_BITS'($urandom_range(0, lo - 1'b1));
        end
        default: begin
          lo = VALUE_BITS'($urandom_range(1, 1 << 20));
          hi = VALUE_MAX;
        end
      endcase
      set_bounds(lo, hi);
      // phase 1 only: back-to-back requests while the result side holds off, filling the block up
      quiet = (p == 1);
      hold_req = (p == 1);
      repeat (PHASE_ITEMS) offer_candidate(next_candidate(), 1'b0, '0);
    end

    drain_results();
    repeat (20) @(posedge clk_i);

    $display("covered %0d requests (%0d directed), %0d results checked: %0d prime, %0d outside",
             n_sent, n_directed, n_checked, n_prime, n_outside);
    $display("bounds: full range, narrow and inverted windows; one %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
